// ===== rtl/rc4_keystream_xor_unit_defines.svh =====
// assertion macros used by the rc4 keystream core
`ifndef RC4_KEYSTREAM_XOR_UNIT_DEFINES_SVH
`define RC4_KEYSTREAM_XOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RC4KX_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("rc4kx assertion failed");

`define RC4KX_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("rc4kx assertion failed");

`else

`define RC4KX_ASSERT_IMPL(label, lhs, rhs)

`define RC4KX_ASSERT_NEXT(label, lhs, rhs)

`endif

`endif

// ===== rtl/rc4kx_pkg.sv =====
// types and constants of the rc4 keystream xor unit
package rc4kx_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned S_DEPTH = 256;

  localparam logic [CMD_W-1:0] CMD_WRITE_ENTRY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_PTRS    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CRYPT       = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    byte_t            entry_index;
    byte_t            entry_value;
    byte_t            i_start;
    byte_t            j_start;
    byte_t            data_in;
    logic             last_in;
  } in_beat_t;

  typedef struct packed {
    byte_t data_out;
    logic  last_out;
  } out_beat_t;

  typedef struct packed {
    logic      ready;
    logic      key_vld;
    out_beat_t res;
  } core_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_J,
    ST_RD_T,
    ST_KEY
  } state_t;

endpackage

// ===== rtl/rc4kx_core.sv =====
// permutation memory, pointers and per-byte read-modify-write sequencer
`include "rc4_keystream_xor_unit_defines.svh"

module rc4kx_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_go,
  input  rc4kx_pkg::in_beat_t beat,
  input  logic                out_free,
  output rc4kx_pkg::core_stat_t stat
);
  import rc4kx_pkg::*;

  byte_t  mem [S_DEPTH];
  byte_t  rdata_r;

  state_t state_r, state_nxt;
  byte_t  i_r, i_nxt;
  byte_t  j_r, j_nxt;
  byte_t  si_r, sj_r;
  logic   fwd_r;
  byte_t  data_r;
  logic   last_r;

  logic   mem_we, mem_re;
  byte_t  mem_waddr, mem_wdata, mem_raddr;
  byte_t  j_sum, t_addr, key;
  logic   is_crypt;

  assign is_crypt = (beat.cmd == CMD_CRYPT);
  assign j_sum    = j_r + rdata_r;
  assign t_addr   = si_r + rdata_r;
  assign key      = fwd_r ? sj_r : rdata_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_go && is_crypt) state_nxt = ST_RD_J;
      ST_RD_J: state_nxt = ST_RD_T;
      ST_RD_T: state_nxt = ST_KEY;
      ST_KEY: begin
        if (out_free) state_nxt = (in_go && is_crypt) ? ST_RD_J : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port control and status
  always_comb begin
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_waddr         = beat.entry_index;
    mem_wdata         = beat.entry_value;
    mem_raddr         = i_r + 8'd1;
    stat.ready        = 1'b0;
    stat.key_vld      = 1'b0;
    stat.res.data_out = data_r ^ key;
    stat.res.last_out = last_r;
    unique case (state_r)
      ST_IDLE, ST_KEY: begin
        stat.ready   = (state_r == ST_IDLE) || out_free;
        stat.key_vld = (state_r == ST_KEY);
        if (in_go) begin
          mem_we = (beat.cmd == CMD_WRITE_ENTRY);
          mem_re = is_crypt;
        end
      end
      ST_RD_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_sum;
        mem_wdata = rdata_r;
        mem_re    = 1'b1;
        mem_raddr = j_sum;
      end
      ST_RD_T: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rdata_r;
        mem_re    = 1'b1;
        mem_raddr = t_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // read-first: a read and a write of the same entry return the old value
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (in_go && beat.cmd == CMD_SET_PTRS) begin
      i_nxt = beat.i_start;
      j_nxt = beat.j_start;
    end else if (in_go && is_crypt) begin
      i_nxt = i_r + 8'd1;
    end else if (state_r == ST_RD_J) begin
      j_nxt = j_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && is_crypt) begin
      data_r <= beat.data_in;
      last_r <= beat.last_in;
    end
    if (state_r == ST_RD_J) si_r <= rdata_r;
    if (state_r == ST_RD_T) begin
      sj_r  <= rdata_r;
      // s[i] is written in the same cycle as the keystream read
      fwd_r <= (t_addr == i_r);
    end
  end

  `RC4KX_ASSERT_NEXT(a_crypt_start, in_go && is_crypt, state_r == ST_RD_J)
  `RC4KX_ASSERT_NEXT(a_rd_j_then_t, state_r == ST_RD_J, state_r == ST_RD_T)
  `RC4KX_ASSERT_IMPL(a_go_when_ready, in_go, state_r == ST_IDLE || state_r == ST_KEY)
  `RC4KX_ASSERT_NEXT(a_key_held, stat.key_vld && !out_free,
                     stat.key_vld && $stable(stat.res))

endmodule

// ===== rtl/rc4_keystream_xor_unit.sv =====
// top level of the rc4 keystream xor unit
// usage:
//   in channel (in_valid, in_stall, in_data) carries commands: write one
//   permutation entry, set the i and j pointers, or crypt one data byte.
//   out channel (out_valid, out_stall, out_data) carries one beat per crypt
//   command: data byte xor keystream byte, with the last marker copied.
//   load commands give no beat.
//   an accepted crypt beat steps through the states ST_RD_J, ST_RD_T and
//   ST_KEY; in ST_KEY its result is loaded into the output register once
//   that is free. no new crypt beat is taken before then, as it waits on
//   the three dependent reads of s[i], s[j] and s[t] through the single
//   read port of the permutation memory. the next beat is accepted in the
//   same cycle the result moves to the output register.
//   if the receiver stalls while a result waits, a finished keystream byte is
//   held in the core and in_stall rises until the output register drains.
//   reset clears the pointers to zero and empties the output register; the
//   permutation memory is not cleared and every entry must be written before
//   the first crypt beat.
module rc4_keystream_xor_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rc4kx_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rc4kx_pkg::out_beat_t out_data
);
  import rc4kx_pkg::*;

  core_stat_t stat;
  logic       in_go, out_free, out_load;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_r;

  assign in_stall = !stat.ready;
  assign in_go    = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = stat.key_vld && out_free;

  rc4kx_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_go    (in_go),
    .beat     (in_data),
    .out_free (out_free),
    .stat     (stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= stat.res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/rc4_keystream_xor_unit_tb.sv =====
// testbench of the rc4 keystream xor unit: directed table and random beats checked by a predictor
module rc4_keystream_xor_unit_tb;
  import rc4kx_pkg::*;

  localparam int unsigned RANDOM_BEATS = 550;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  rc4_keystream_xor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  byte_t       perm [S_DEPTH];
  byte_t       ks_i = '0;
  byte_t       ks_j = '0;
  out_beat_t   crypt_q [$];

  int unsigned errors = 0;
  int unsigned n_writes = 0;
  int unsigned n_ptrs = 0;
  int unsigned n_crypts = 0;
  int unsigned n_ignored = 0;
  int unsigned n_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  logic [7:0]  stall_tick = '0;

  function automatic in_beat_t random_beat(logic [CMD_W-1:0] cmd);
    in_beat_t b;
    b.cmd         = cmd;
    b.entry_index = byte_t'($urandom);
    b.entry_value = byte_t'($urandom);
    b.i_start     = byte_t'($urandom);
    b.j_start     = byte_t'($urandom);
    b.data_in     = byte_t'($urandom);
    b.last_in     = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic dir_row_t row(logic [CMD_W-1:0] cmd, byte_t idx, byte_t val,
                                   byte_t i_st, byte_t j_st, byte_t din, logic last,
                                   bit typed = 1'b0, byte_t exp_data = '0,
                                   logic exp_last = 1'b0);
    dir_row_t r;
    r.beat.cmd         = cmd;
    r.beat.entry_index = idx;
    r.beat.entry_value = val;
    r.beat.i_start     = i_st;
    r.beat.j_start     = j_st;
    r.beat.data_in     = din;
    r.beat.last_in     = last;
    r.typed            = typed;
    r.res.data_out     = exp_data;
    r.res.last_out     = exp_last;
    return r;
  endfunction

  function automatic bit advance_cipher(input in_beat_t b, output out_beat_t res);
    byte_t si;
    byte_t sj;
    res = '0;
    case (b.cmd)
      CMD_WRITE_ENTRY: begin
        perm[b.entry_index] = b.entry_value;
        n_writes++;
        return 1'b0;
      end
      CMD_SET_PTRS: begin
        ks_i = b.i_start;
        ks_j = b.j_start;
        n_ptrs++;
        return 1'b0;
      end
      CMD_CRYPT: begin
        ks_i = ks_i + 8'd1;
        si = perm[ks_i];
        ks_j = ks_j + si;
        sj = perm[ks_j];
        perm[ks_i] = sj;
        perm[ks_j] = si;
        res.data_out = b.data_in ^ perm[byte_t'(si + sj)];
        res.last_out = b.last_in;
        n_crypts++;
        return 1'b1;
      end
      default: begin
        n_ignored++;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed = 1'b0,
                           input out_beat_t typed_res = '0);
    int unsigned gap;
    out_beat_t   res;
    bit          has_res;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    has_res = advance_cipher(b, res);
    if (has_res) crypt_q.push_back(typed ? typed_res : res);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               crypt_q.size());
      $display("** rc4_keystream_xor_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_tick <= stall_tick + 8'd1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[3];
      endcase
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (crypt_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat data_out %h last_out %b", $time,
                 out_data.data_out, out_data.last_out);
      end else begin
        want = crypt_q.pop_front();
        n_checked++;
        if (out_data.data_out !== want.data_out) begin
          errors++;
          $display("%0t: data_out expected %h got %h", $time, want.data_out,
                   out_data.data_out);
        end
        if (out_data.last_out !== want.last_out) begin
          errors++;
          $display("%0t: last_out expected %b got %b", $time, want.last_out,
                   out_data.last_out);
        end
      end
    end
  end

  initial begin
    dir_row_t    dir_rows [$];
    in_beat_t    b;
    int unsigned k;
    int unsigned counted;
    int unsigned buf_len;
    int unsigned pick;

    foreach (perm[n]) perm[n] = '0;

    // identity table, pointers left at their reset value
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                           1'b1, 8'h02, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
    dir_rows.push_back(row(CMD_SET_PTRS, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'ha5, 1'b1,
                           1'b1, 8'ha5, 1'b1));
    dir_rows.push_back(row(CMD_WRITE_ENTRY, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1));
    dir_rows.push_back(row(CMD_WRITE_ENTRY, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
    dir_rows.push_back(row(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_SET_PTRS, 8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 1'b1));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a, 1'b0));
    // duplicate values, table no longer a permutation
    dir_rows.push_back(row(CMD_WRITE_ENTRY, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_WRITE_ENTRY, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_SET_PTRS, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1));
    dir_rows.push_back(row(CMD_SET_PTRS, 8'h00, 8'h00, 8'h7f, 8'h80, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3c, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hc3, 1'b1));
    dir_rows.push_back(row(CMD_WRITE_ENTRY, 8'h80, 8'h7f, 8'h00, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0));
    dir_rows.push_back(row(CMD_CRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < S_DEPTH; k++) begin
      b = random_beat(CMD_WRITE_ENTRY);
      b.entry_index = byte_t'(k);
      b.entry_value = byte_t'(k);
      send_beat(b);
    end

    foreach (dir_rows[r]) send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].res);

    counted = 0;
    while (counted < RANDOM_BEATS) begin
      if ($urandom_range(0, 7) == 0) begin
        send_beat(random_beat(CMD_SET_PTRS));
        counted++;
      end
      buf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
      for (k = 0; k < buf_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_beat(random_beat(CMD_WRITE_ENTRY));
          counted++;
        end else if (pick < 11) begin
          send_beat(random_beat(CMD_UNUSED));
        end
        b = random_beat(CMD_CRYPT);
        b.last_in = (k == buf_len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0);
        send_beat(b);
        counted++;
      end
    end
    in_valid <= 1'b0;

    while (crypt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d table writes, %0d pointer loads, %0d crypt beats, %0d ignored commands",
             n_writes, n_ptrs, n_crypts, n_ignored);
    $display("checked %0d result beats with %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("** rc4_keystream_xor_unit: PASSED **");
    end else begin
      $display("** rc4_keystream_xor_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rc4kx_pkg.sv
rtl/rc4kx_core.sv
rtl/rc4_keystream_xor_unit.sv
tb/rc4_keystream_xor_unit_tb.sv
